// ===== rtl/owms_pkg.sv =====
// shared types and constants of the 1-wire master slot engine
package owms_pkg;

    localparam int TIMER_WIDTH_DEF = 10;
    localparam int BITS_PER_BYTE   = 8;

    localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
    localparam logic [9:0] PRESENCE_WAIT_DEF = 10'd70;
    localparam logic [9:0] RESET_TAIL_DEF    = 10'd410;
    localparam logic [7:0] WRITE_ONE_DEF     = 8'd6;
    localparam logic [7:0] WRITE_ZERO_DEF    = 8'd60;
    localparam logic [7:0] READ_LOW_DEF      = 8'd6;
    localparam logic [7:0] READ_SAMPLE_DEF   = 8'd9;
    localparam logic [7:0] SLOT_DEF          = 8'd70;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_RST_LOW   = 3'd1,
        PH_RST_WAIT  = 3'd2,
        PH_RST_TAIL  = 3'd3,
        PH_SLOT_LOW  = 3'd4,
        PH_SLOT_WAIT = 3'd5,
        PH_SLOT_PAD  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_RESET_TAIL    = 3'd2,
        CFG_WRITE_ONE     = 3'd3,
        CFG_WRITE_ZERO    = 3'd4,
        CFG_READ_LOW      = 3'd5,
        CFG_READ_SAMPLE   = 3'd6,
        CFG_SLOT          = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] write_data;
        logic       bus_level;
    } in_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } out_item_t;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [9:0] presence_wait_us;
        logic [9:0] reset_tail_us;
        logic [7:0] write_one_low_us;
        logic [7:0] write_zero_low_us;
        logic [7:0] read_low_us;
        logic [7:0] read_sample_us;
        logic [7:0] slot_us;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] bit_index;
        logic [7:0] shift_data;
        op_t        op_kind;
        logic       presence_flag;
        logic [7:0] last_read;
    } ctl_state_t;

endpackage

// ===== rtl/onewire_master_slot_engine.sv =====
// top level of the 1-wire master slot engine
// Each input word is one microsecond tick, optionally carrying a command (reset, byte write,
// byte read); each accepted word yields exactly one result word with the line drive, status
// and last presence and read results. Words pass through an input register and a result
// register with the engine's counter and phase update in between, so one word is taken per
// clock when the output side keeps up; the result word is offered from the result register
// once its input word has passed from the input register through the update.
// Configuration writes take effect at once and are meant to be made while the engine is idle.
module onewire_master_slot_engine #(
    parameter int TIMER_WIDTH = owms_pkg::TIMER_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  owms_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output owms_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [9:0]          cfg_data
);

    owms_pkg::cfg_t          cfg_reg;
    owms_pkg::ctl_state_t    state_reg;
    owms_pkg::ctl_state_t    state_next;
    logic [TIMER_WIDTH-1:0]  tick_reg;
    logic [TIMER_WIDTH-1:0]  tick_next;
    logic                    in_valid_reg;
    owms_pkg::in_item_t      in_word_reg;
    logic                    out_valid_reg;
    owms_pkg::out_item_t     out_word_reg;
    owms_pkg::out_item_t     step_result;
    logic                    advance;

    assign advance   = ~out_valid_reg | out_ready;
    assign in_ready  = ~in_valid_reg | advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us      <= owms_pkg::RESET_LOW_DEF;
            cfg_reg.presence_wait_us  <= owms_pkg::PRESENCE_WAIT_DEF;
            cfg_reg.reset_tail_us     <= owms_pkg::RESET_TAIL_DEF;
            cfg_reg.write_one_low_us  <= owms_pkg::WRITE_ONE_DEF;
            cfg_reg.write_zero_low_us <= owms_pkg::WRITE_ZERO_DEF;
            cfg_reg.read_low_us       <= owms_pkg::READ_LOW_DEF;
            cfg_reg.read_sample_us    <= owms_pkg::READ_SAMPLE_DEF;
            cfg_reg.slot_us           <= owms_pkg::SLOT_DEF;
        end
        else if (cfg_valid)
        begin
            unique case (owms_pkg::cfg_idx_t'(cfg_index))
                owms_pkg::CFG_RESET_LOW:     cfg_reg.reset_low_us      <= cfg_data;
                owms_pkg::CFG_PRESENCE_WAIT: cfg_reg.presence_wait_us  <= cfg_data;
                owms_pkg::CFG_RESET_TAIL:    cfg_reg.reset_tail_us     <= cfg_data;
                owms_pkg::CFG_WRITE_ONE:     cfg_reg.write_one_low_us  <= cfg_data[7:0];
                owms_pkg::CFG_WRITE_ZERO:    cfg_reg.write_zero_low_us <= cfg_data[7:0];
                owms_pkg::CFG_READ_LOW:      cfg_reg.read_low_us       <= cfg_data[7:0];
                owms_pkg::CFG_READ_SAMPLE:   cfg_reg.read_sample_us    <= cfg_data[7:0];
                owms_pkg::CFG_SLOT:          cfg_reg.slot_us           <= cfg_data[7:0];
                default:                     cfg_reg.slot_us           <= cfg_reg.slot_us;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_word_reg <= in_data;
    end

    owms_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .cfg       (cfg_reg),
        .item      (in_word_reg),
        .cur       (state_reg),
        .tick_cur  (tick_reg),
        .nxt_state (state_next),
        .tick_nxt  (tick_next),
        .result    (step_result)
    );

    // engine state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= owms_pkg::PH_IDLE;
            state_reg.bit_index     <= '0;
            state_reg.shift_data    <= '0;
            state_reg.op_kind       <= owms_pkg::OP_TICK;
            state_reg.presence_flag <= 1'b0;
            state_reg.last_read     <= '0;
            tick_reg                <= '0;
            out_valid_reg           <= 1'b0;
        end
        else if (in_valid_reg && advance)
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
            out_word_reg <= step_result;
    end

endmodule

// ===== rtl/owms_step.sv =====
// next-state and result logic for one tick or command word
module owms_step #(
    parameter int TIMER_WIDTH = owms_pkg::TIMER_WIDTH_DEF
) (
    input  owms_pkg::cfg_t         cfg,
    input  owms_pkg::in_item_t     item,
    input  owms_pkg::ctl_state_t   cur,
    input  logic [TIMER_WIDTH-1:0] tick_cur,
    output owms_pkg::ctl_state_t   nxt_state,
    output logic [TIMER_WIDTH-1:0] tick_nxt,
    output owms_pkg::out_item_t    result
);

    localparam int CW = (TIMER_WIDTH > 10) ? TIMER_WIDTH : 10;
    localparam int RW = CW + 2;
    localparam logic [CW-1:0] TMAX_C = CW'((1 << TIMER_WIDTH) - 1);

    function automatic logic [TIMER_WIDTH-1:0] clamp_len(input logic [9:0] v);
        logic [CW-1:0] ve;
        ve = CW'(v);
        if (ve == '0)
            clamp_len = TIMER_WIDTH'(1);
        else if (ve > TMAX_C)
            clamp_len = '1;
        else
            clamp_len = TIMER_WIDTH'(ve);
    endfunction

    owms_pkg::ctl_state_t     s;
    owms_pkg::phase_t         ph_after;
    logic [TIMER_WIDTH-1:0]   tc;
    logic [TIMER_WIDTH-1:0]   len;
    logic [TIMER_WIDTH-1:0]   low_len;
    logic [TIMER_WIDTH-1:0]   sample_len;
    logic signed [RW-1:0]     rest;
    logic [7:0]               low_raw;
    logic                     drv;
    logic                     done;
    logic                     rej;
    logic                     run;

    always_comb
    begin
        s        = cur;
        tc       = tick_cur;
        drv      = 1'b0;
        done     = 1'b0;
        rej      = 1'b0;
        run      = 1'b1;
        len      = TIMER_WIDTH'(1);
        ph_after = owms_pkg::PH_IDLE;

        // command start
        if (item.mode != owms_pkg::OP_TICK)
        begin
            if (s.phase == owms_pkg::PH_IDLE)
            begin
                s.op_kind   = owms_pkg::op_t'(item.mode);
                tc          = '0;
                s.bit_index = '0;
                if (item.mode == owms_pkg::OP_RESET)
                begin
                    s.phase = owms_pkg::PH_RST_LOW;
                end
                else
                begin
                    s.phase      = owms_pkg::PH_SLOT_LOW;
                    s.shift_data = (item.mode == owms_pkg::OP_WRITE) ? item.write_data : 8'd0;
                end
            end
            else
            begin
                rej = 1'b1;
            end
        end

        // low pulse length of the current slot
        if (s.op_kind == owms_pkg::OP_WRITE)
            low_raw = s.shift_data[s.bit_index] ? cfg.write_one_low_us : cfg.write_zero_low_us;
        else
            low_raw = cfg.read_low_us;
        low_len    = clamp_len(10'(low_raw));
        sample_len = clamp_len(10'(cfg.read_sample_us));
        rest       = $signed(RW'(cfg.slot_us)) - $signed(RW'(low_len));
        if (s.op_kind == owms_pkg::OP_READ)
            rest = rest - $signed(RW'(sample_len));

        unique case (s.phase)
            owms_pkg::PH_RST_LOW:
            begin
                drv      = 1'b1;
                len      = clamp_len(cfg.reset_low_us);
                ph_after = owms_pkg::PH_RST_WAIT;
            end
            owms_pkg::PH_RST_WAIT:
            begin
                len      = clamp_len(cfg.presence_wait_us);
                ph_after = owms_pkg::PH_RST_TAIL;
            end
            owms_pkg::PH_RST_TAIL:
            begin
                if (tc == '0)
                    s.presence_flag = ~item.bus_level;
                len      = clamp_len(cfg.reset_tail_us);
                ph_after = owms_pkg::PH_IDLE;
            end
            owms_pkg::PH_SLOT_LOW:
            begin
                drv      = 1'b1;
                len      = low_len;
                ph_after = (s.op_kind == owms_pkg::OP_READ) ? owms_pkg::PH_SLOT_WAIT
                                                            : owms_pkg::PH_SLOT_PAD;
            end
            owms_pkg::PH_SLOT_WAIT:
            begin
                len      = sample_len;
                ph_after = owms_pkg::PH_SLOT_PAD;
            end
            owms_pkg::PH_SLOT_PAD:
            begin
                if (s.op_kind == owms_pkg::OP_READ && tc == '0)
                    s.shift_data = s.shift_data | (8'(item.bus_level) << s.bit_index);
                if (rest < $signed(RW'(1)))
                    len = TIMER_WIDTH'(1);
                else
                    len = TIMER_WIDTH'(rest);
                ph_after = owms_pkg::PH_SLOT_LOW;
            end
            default:
            begin
                s.phase = owms_pkg::PH_IDLE;
                run     = 1'b0;
            end
        endcase

        if (run)
        begin
            tc = tc + TIMER_WIDTH'(1);
            if (tc >= len)
            begin
                tc = '0;
                if (s.phase == owms_pkg::PH_SLOT_PAD)
                begin
                    if ({1'b0, s.bit_index} + 4'd1 >= 4'(owms_pkg::BITS_PER_BYTE))
                    begin
                        if (s.op_kind == owms_pkg::OP_READ)
                            s.last_read = s.shift_data;
                        s.phase = owms_pkg::PH_IDLE;
                        done    = 1'b1;
                    end
                    else
                    begin
                        s.bit_index = s.bit_index + 3'd1;
                        s.phase     = owms_pkg::PH_SLOT_LOW;
                    end
                end
                else
                begin
                    s.phase = ph_after;
                    if (ph_after == owms_pkg::PH_IDLE)
                        done = 1'b1;
                end
            end
        end

        nxt_state          = s;
        tick_nxt           = tc;
        result.drive_low   = drv;
        result.busy_res    = (s.phase != owms_pkg::PH_IDLE);
        result.done_res    = done;
        result.presence    = s.presence_flag;
        result.read_data   = s.last_read;
        result.rejected    = rej;
    end

endmodule

// ===== rtl/owms_checker.sv =====
// port-level checks for the 1-wire master slot engine, bound to the top level
module owms_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input owms_pkg::out_item_t out_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // completion tick reports idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.busy_res)
        else $error("done with busy set");

    // a low drive is always followed by more of the operation
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.drive_low |-> out_data.busy_res && !out_data.done_res)
        else $error("line driven low outside a running operation");

endmodule

bind onewire_master_slot_engine owms_checker u_owms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
